>>> rtl/core/spherical_angles_to_unit_vector_defines.svh
// Assertion macros shared by the spherical-to-unit-vector RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SPHERICAL_ANGLES_TO_UNIT_VECTOR_DEFINES_SVH
`define SPHERICAL_ANGLES_TO_UNIT_VECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SAV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sav: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SAV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sav: assertion failed");

`endif

>>> rtl/core/sav_pkg.sv
// Shared constants, tables and types for the spherical-to-unit-vector block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sav_pkg;

  localparam int unsigned DEG_W        = 16;     // input angle width
  localparam int unsigned OUT_W        = 16;     // Q1.14 result width
  localparam int unsigned LANES        = 2;      // azimuth and polar paths
  localparam int unsigned LANE_AZ      = 0;
  localparam int unsigned LANE_POL     = 1;

  localparam int unsigned TURN_UNITS   = 23040;  // 360 deg in 1/64 deg
  localparam int unsigned MOD_W        = 15;     // holds [0, TURN_UNITS)
  localparam int unsigned DIV45        = 45;     // TURN_UNITS = 45 * 512
  localparam int unsigned QUOT_W       = 9;      // m / 45 < 512
  localparam int unsigned REM_W        = 6;      // m % 45 < 64
  localparam int unsigned RECIP45      = 23302;  // ceil(2^20 / 45)
  localparam int unsigned RECIP_SHIFT  = 20;
  localparam int unsigned FRAC_LO_W    = 23;     // 2^32 / 512
  localparam int unsigned FRAC_BIAS    = (TURN_UNITS / 2) / (TURN_UNITS / DIV45);

  localparam int unsigned ANG_W        = 32;     // binary angle, 2^32 per turn
  localparam int unsigned XY_W         = 32;     // CORDIC datapath, 30 frac bits
  localparam int unsigned FRAC_W       = 30;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned TRIG_STAGES_DEF = 16;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // atan(2^-i) in 2^32-per-turn units
  localparam logic signed [ANG_W-1:0] ATAN_TBL [ATAN_ENTRIES] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
    32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
    32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
    32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
    32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
  };

  localparam logic signed [OUT_W-1:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [OUT_W-1:0] NEG_ONE_Q14 = -16'sd16384;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } sav_quad_e;

  // reduced angle handed to the rotator
  typedef struct packed {
    sav_quad_e               quad;
    logic signed [ANG_W-1:0] resid;
  } sav_rot_t;

  // rotator result, quadrant still to be applied
  typedef struct packed {
    sav_quad_e              quad;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } sav_vec_t;

endpackage

`default_nettype wire

>>> rtl/core/sav_reduce.sv
// Angle reduction: wraps 1/64-degree angles to one turn, converts to a
// 32-bit binary angle and splits off the quadrant. Four stages. Uses sav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sav_reduce (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [sav_pkg::DEG_W-1:0]    deg_i [sav_pkg::LANES],
  output logic                                valid_o,
  output sav_pkg::sav_rot_t                   rot_o [sav_pkg::LANES]
);
  import sav_pkg::*;

  localparam int unsigned BIAS_W = MOD_W + 2;
  localparam int unsigned EXT_W  = BIAS_W + 1;
  localparam int unsigned PROD_W = 2 * MOD_W;

  localparam logic [BIAS_W-1:0] TURN1 = BIAS_W'(TURN_UNITS);
  localparam logic [BIAS_W-1:0] TURN2 = BIAS_W'(2 * TURN_UNITS);
  localparam logic [BIAS_W-1:0] TURN3 = BIAS_W'(3 * TURN_UNITS);
  localparam logic [ANG_W-1:0]  HALF_QUAD = ANG_W'(1) << (ANG_W - 3);

  // floor((b * 2^23 + 22) / 45) for each remainder b
  logic [FRAC_LO_W-1:0] frac_tbl [DIV45];
  for (genvar g = 0; g < DIV45; g++) begin : g_frac
    localparam logic [FRAC_LO_W-1:0] FracVal =
      FRAC_LO_W'(((64'(g) << FRAC_LO_W) + 64'(FRAC_BIAS)) / 64'(DIV45));
    assign frac_tbl[g] = FracVal;
  end

  logic [3:0]           v_q;
  logic [MOD_W-1:0]     m1_q [LANES];
  logic [MOD_W-1:0]     m2_q [LANES];
  logic [QUOT_W-1:0]    a2_q [LANES];
  logic [QUOT_W-1:0]    a3_q [LANES];
  logic [REM_W-1:0]     b3_q [LANES];
  sav_rot_t             rot_q [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [EXT_W-1:0]   ext;
    logic [BIAS_W-1:0]  biased;
    logic [BIAS_W-1:0]  wrapped;
    logic [PROD_W-1:0]  prod;
    logic [MOD_W-1:0]   rem_full;
    logic [ANG_W-1:0]   ang;
    logic [ANG_W-1:0]   ang_rot;
    sav_rot_t           rot_d;

    // two turns of bias leave a positive value below four turns
    assign ext    = {{(EXT_W - DEG_W){deg_i[l][DEG_W-1]}}, deg_i[l]}
                    + EXT_W'(2 * TURN_UNITS);
    assign biased = ext[BIAS_W-1:0];

    always_comb begin
      if (biased >= TURN3) begin
        wrapped = biased - TURN3;
      end else if (biased >= TURN2) begin
        wrapped = biased - TURN2;
      end else if (biased >= TURN1) begin
        wrapped = biased - TURN1;
      end else begin
        wrapped = biased;
      end
    end

    // m / 45 by reciprocal, exact for m below one turn
    assign prod     = PROD_W'(m1_q[l]) * PROD_W'(RECIP45);
    assign rem_full = m2_q[l] - MOD_W'(a2_q[l]) * MOD_W'(DIV45);

    assign ang     = {a3_q[l], frac_tbl[b3_q[l]]};
    assign ang_rot = ang + HALF_QUAD;

    always_comb begin
      rot_d.quad  = sav_quad_e'(ang_rot[ANG_W-1 -: 2]);
      rot_d.resid = {{3{~ang_rot[ANG_W-3]}}, ang_rot[ANG_W-4:0]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m1_q[l]  <= wrapped[MOD_W-1:0];
        m2_q[l]  <= m1_q[l];
        a2_q[l]  <= prod[RECIP_SHIFT +: QUOT_W];
        a3_q[l]  <= a2_q[l];
        b3_q[l]  <= rem_full[REM_W-1:0];
        rot_q[l] <= rot_d;
      end
    end

    assign rot_o[l] = rot_q[l];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  assign valid_o = v_q[3];

endmodule

`default_nettype wire

>>> rtl/core/sav_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration, for both angle
// lanes in parallel. Carries the quadrant alongside. Uses sav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sav_cordic #(
  parameter int unsigned STAGES = sav_pkg::TRIG_STAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  sav_pkg::sav_rot_t rot_i [sav_pkg::LANES],
  output logic              valid_o,
  output sav_pkg::sav_vec_t vec_o [sav_pkg::LANES]
);
  import sav_pkg::*;

  logic [STAGES-1:0]       v_q;
  logic signed [XY_W-1:0]  x_q [LANES][STAGES];
  logic signed [XY_W-1:0]  y_q [LANES][STAGES];
  logic signed [ANG_W-1:0] z_q [LANES][STAGES];
  sav_quad_e               q_q [LANES][STAGES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic signed [XY_W-1:0]  x_in;
      logic signed [XY_W-1:0]  y_in;
      logic signed [ANG_W-1:0] z_in;
      sav_quad_e               q_in;

      if (s == 0) begin : g_first
        assign x_in = CORDIC_GAIN;
        assign y_in = '0;
        assign z_in = rot_i[l].resid;
        assign q_in = rot_i[l].quad;
      end else begin : g_next
        assign x_in = x_q[l][s-1];
        assign y_in = y_q[l][s-1];
        assign z_in = z_q[l][s-1];
        assign q_in = q_q[l][s-1];
      end

      // arithmetic shift floors, as the rotator requires
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!z_in[ANG_W-1]) begin
            x_q[l][s] <= x_in - (y_in >>> s);
            y_q[l][s] <= y_in + (x_in >>> s);
            z_q[l][s] <= z_in - ATAN_TBL[s];
          end else begin
            x_q[l][s] <= x_in + (y_in >>> s);
            y_q[l][s] <= y_in - (x_in >>> s);
            z_q[l][s] <= z_in + ATAN_TBL[s];
          end
          q_q[l][s] <= q_in;
        end
      end
    end

    always_comb begin
      vec_o[l].quad = q_q[l][STAGES-1];
      vec_o[l].x    = x_q[l][STAGES-1];
      vec_o[l].y    = y_q[l][STAGES-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  assign valid_o = v_q[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/core/sav_combine.sv
// Quadrant restore, component products, rounding to Q1.14 and saturation.
// Three stages. Uses sav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sav_combine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  sav_pkg::sav_vec_t               vec_i [sav_pkg::LANES],
  output logic                            valid_o,
  output logic signed [sav_pkg::OUT_W-1:0] dir_x_o,
  output logic signed [sav_pkg::OUT_W-1:0] dir_y_o,
  output logic signed [sav_pkg::OUT_W-1:0] dir_z_o
);
  import sav_pkg::*;

  localparam int unsigned PROD_W = 2 * XY_W;
  localparam int unsigned SAT_W  = OUT_W + 2;
  localparam int unsigned PSHIFT = 2 * FRAC_W - (OUT_W - 2);  // Q.60 -> Q.14
  localparam int unsigned ZSHIFT = FRAC_W - (OUT_W - 2);      // Q.30 -> Q.14

  localparam logic signed [PROD_W-1:0] RND_P   = PROD_W'(1) << (PSHIFT - 1);
  localparam logic signed [XY_W-1:0]   RND_Z   = XY_W'(1) << (ZSHIFT - 1);
  localparam logic signed [SAT_W-1:0]  POS_LIM = SAT_W'(ONE_Q14);
  localparam logic signed [SAT_W-1:0]  NEG_LIM = -SAT_W'(ONE_Q14);

  function automatic logic signed [OUT_W-1:0] sat_unit(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] c;
    if (v > POS_LIM) begin
      c = POS_LIM;
    end else if (v < NEG_LIM) begin
      c = NEG_LIM;
    end else begin
      c = v;
    end
    return c[OUT_W-1:0];
  endfunction

  logic [2:0]               v_q;
  logic signed [XY_W-1:0]   cos_q [LANES];
  logic signed [XY_W-1:0]   sin_q [LANES];
  logic signed [PROD_W-1:0] px_q;
  logic signed [PROD_W-1:0] py_q;
  logic signed [OUT_W-1:0]  z2_q;
  logic signed [OUT_W-1:0]  x3_q;
  logic signed [OUT_W-1:0]  y3_q;
  logic signed [OUT_W-1:0]  z3_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [XY_W-1:0] cos_d;
    logic signed [XY_W-1:0] sin_d;

    always_comb begin
      case (vec_i[l].quad)
        QUAD_0: begin
          cos_d = vec_i[l].x;
          sin_d = vec_i[l].y;
        end
        QUAD_1: begin
          cos_d = -vec_i[l].y;
          sin_d = vec_i[l].x;
        end
        QUAD_2: begin
          cos_d = -vec_i[l].x;
          sin_d = -vec_i[l].y;
        end
        QUAD_3: begin
          cos_d = vec_i[l].y;
          sin_d = -vec_i[l].x;
        end
        default: begin
          cos_d = vec_i[l].x;
          sin_d = vec_i[l].y;
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cos_q[l] <= cos_d;
        sin_q[l] <= sin_d;
      end
    end
  end

  logic signed [PROD_W-1:0] px_d;
  logic signed [PROD_W-1:0] py_d;
  logic signed [XY_W-1:0]   zr;
  logic signed [PROD_W-1:0] pxr;
  logic signed [PROD_W-1:0] pyr;

  assign px_d = PROD_W'(cos_q[LANE_AZ]) * PROD_W'(sin_q[LANE_POL]);
  assign py_d = PROD_W'(sin_q[LANE_AZ]) * PROD_W'(sin_q[LANE_POL]);
  assign zr   = cos_q[LANE_POL] + RND_Z;
  assign pxr  = px_q + RND_P;
  assign pyr  = py_q + RND_P;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px_d;
      py_q <= py_d;
      z2_q <= sat_unit(SAT_W'(zr >>> ZSHIFT));
      x3_q <= sat_unit(pxr[PROD_W-1 -: SAT_W]);
      y3_q <= sat_unit(pyr[PROD_W-1 -: SAT_W]);
      z3_q <= z2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  assign valid_o = v_q[2];
  assign dir_x_o = x3_q;
  assign dir_y_o = y3_q;
  assign dir_z_o = z3_q;

endmodule

`default_nettype wire

>>> rtl/core/spherical_angles_to_unit_vector.sv
// Register stages from input accept to output valid: 4 reduction, one per CORDIC
// iteration, 3 combine, 1 output register.
// Throughput: one item per cycle while the skid entry is empty; the CORDIC stage chain sets the depth.
// Output side has a register plus one skid entry, so in_ready_o is registered.
// Reset (rst_ni low, async) clears all valid bits and the skid flag.
`timescale 1ns / 1ps
`default_nettype none
`include "spherical_angles_to_unit_vector_defines.svh"

module spherical_angles_to_unit_vector #(
  parameter int unsigned TRIG_STAGES = sav_pkg::TRIG_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [sav_pkg::DEG_W-1:0] azimuth_deg_i,
  input  logic signed [sav_pkg::DEG_W-1:0] polar_deg_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [sav_pkg::OUT_W-1:0] dir_x_o,
  output logic signed [sav_pkg::OUT_W-1:0] dir_y_o,
  output logic signed [sav_pkg::OUT_W-1:0] dir_z_o
);
  import sav_pkg::*;

  localparam int unsigned RUN_STAGES =
    (TRIG_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_STAGES;

  logic                    en;
  logic signed [DEG_W-1:0] deg [LANES];
  logic                    red_valid;
  sav_rot_t                rot [LANES];
  logic                    cor_valid;
  sav_vec_t                vec [LANES];
  logic                    cmb_valid;
  logic signed [OUT_W-1:0] cmb_x;
  logic signed [OUT_W-1:0] cmb_y;
  logic signed [OUT_W-1:0] cmb_z;

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_x_q, out_y_q, out_z_q;
  logic                    skid_full_q;
  logic signed [OUT_W-1:0] skid_x_q, skid_y_q, skid_z_q;
  logic                    push;
  logic                    pop;

  // whole pipeline advances unless the skid entry is occupied
  assign en         = !skid_full_q;
  assign in_ready_o = en;

  assign deg[LANE_AZ]  = azimuth_deg_i;
  assign deg[LANE_POL] = polar_deg_i;

  sav_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .deg_i   (deg),
    .valid_o (red_valid),
    .rot_o   (rot)
  );

  sav_cordic #(
    .STAGES (RUN_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (red_valid),
    .rot_i   (rot),
    .valid_o (cor_valid),
    .vec_o   (vec)
  );

  sav_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cor_valid),
    .vec_i   (vec),
    .valid_o (cmb_valid),
    .dir_x_o (cmb_x),
    .dir_y_o (cmb_y),
    .dir_z_o (cmb_z)
  );

  assign push = en && cmb_valid;
  assign pop  = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (pop) begin
        skid_full_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_full_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (pop) begin
        out_x_q <= skid_x_q;
        out_y_q <= skid_y_q;
        out_z_q <= skid_z_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_x_q <= cmb_x;
        out_y_q <= cmb_y;
        out_z_q <= cmb_z;
      end else begin
        skid_x_q <= cmb_x;
        skid_y_q <= cmb_y;
        skid_z_q <= cmb_z;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign dir_x_o     = out_x_q;
  assign dir_y_o     = out_y_q;
  assign dir_z_o     = out_z_q;

  `SAV_ASSERT_IMP(a_skid_has_out, clk_i, rst_ni, skid_full_q, out_valid_q)
  `SAV_ASSERT_IMP(a_out_in_range, clk_i, rst_ni, out_valid_q, (out_x_q <= ONE_Q14) && (out_x_q >= NEG_ONE_Q14) && (out_y_q <= ONE_Q14) && (out_y_q >= NEG_ONE_Q14) && (out_z_q <= ONE_Q14) && (out_z_q >= NEG_ONE_Q14))
  `SAV_ASSERT_NXT(a_stall_fills_skid, clk_i, rst_ni, out_valid_q && !out_ready_i && push, skid_full_q && out_valid_q)
  `SAV_ASSERT_NXT(a_skid_drains, clk_i, rst_ni, skid_full_q && out_ready_i, out_valid_q && !skid_full_q)

endmodule

`default_nettype wire

>>> tb/sv/spherical_angles_to_unit_vector_test.sv
// Self-checking bench for spherical_angles_to_unit_vector: angle pairs in,
// Q1.14 direction vectors out, checked against a CORDIC predictor.
// Depends on sav_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module spherical_angles_to_unit_vector_test;

  import sav_pkg::*;

  localparam int unsigned TRIG_STAGES = TRIG_STAGES_DEF;
  localparam int          N_RANDOM    = 1030;
  localparam int          TAIL_CYCLES = 24 + 8 + 16;
  localparam int          CYCLE_LIMIT = 400000;

  localparam int     DEG_RANGE    = 23040;               // full turn, 1/64 deg
  localparam longint HALF_TURN_BA = 64'sh0_8000_0000;    // binary angle units
  localparam longint FULL_TURN_BA = 64'sh1_0000_0000;
  localparam longint QUARTER_BA   = 64'sh0_4000_0000;
  localparam longint EIGHTH_BA    = 64'sh0_2000_0000;
  localparam longint GAIN_Q30     = 64'sd652032874;
  localparam longint UNIT_Q14     = 64'sd16384;
  localparam int     ATAN_N       = 24;

  localparam longint ATAN_TURNS [ATAN_N] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct {
    logic signed [DEG_W-1:0] az;
    logic signed [DEG_W-1:0] pol;
    bit                      drain;  // hold off until all results are back
  } angle_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } unit_vec_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [DEG_W-1:0] azimuth;
  logic signed [DEG_W-1:0] polar;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OUT_W-1:0] dir_x;
  logic signed [OUT_W-1:0] dir_y;
  logic signed [OUT_W-1:0] dir_z;

  angle_item_t angle_queue[$];
  unit_vec_t   expected_dirs[$];
  int unsigned n_acc;
  int unsigned n_rcv;
  int unsigned n_total;
  int          errors = 0;
  int          cycle_count = 0;
  int          gap_left;
  int          burst_left;
  logic [7:0]  stall_mask;
  logic [5:0]  stall_phase;

  spherical_angles_to_unit_vector #(
    .TRIG_STAGES(TRIG_STAGES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .azimuth_deg_i(azimuth),
    .polar_deg_i  (polar),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .dir_x_o      (dir_x),
    .dir_y_o      (dir_y),
    .dir_z_o      (dir_z)
  );

  // cos and sin of an angle in 1/64 deg, both with 30 fraction bits
  function automatic void trig_q30(input logic signed [DEG_W-1:0] deg,
                                   output longint cos_v, output longint sin_v);
    longint    m, ang, resid, x, y, z, xs, ys;
    sav_quad_e quad;
    int        n;
    m = longint'(deg) % DEG_RANGE;
    if (m < 0) m += DEG_RANGE;
    ang = ((m << 32) + DEG_RANGE / 2) / DEG_RANGE;
    ang = ang & 64'hFFFF_FFFF;
    quad = sav_quad_e'(((ang + EIGHTH_BA) >> 30) & 3);
    resid = (ang - longint'(quad) * QUARTER_BA) & 64'hFFFF_FFFF;
    if (resid >= HALF_TURN_BA) resid -= FULL_TURN_BA;
    x = GAIN_Q30;
    y = 0;
    z = resid;
    n = (TRIG_STAGES > ATAN_N) ? ATAN_N : TRIG_STAGES;
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TURNS[i];
      end
    end
    case (quad)
      QUAD_0: begin cos_v = x;  sin_v = y;  end
      QUAD_1: begin cos_v = -y; sin_v = x;  end
      QUAD_2: begin cos_v = -x; sin_v = -y; end
      default: begin cos_v = y; sin_v = -x; end
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_q14(input longint v);
    if (v > UNIT_Q14) return OUT_W'(UNIT_Q14);
    if (v < -UNIT_Q14) return OUT_W'(-UNIT_Q14);
    return OUT_W'(v);
  endfunction

  function automatic unit_vec_t unit_dir_of(input logic signed [DEG_W-1:0] az,
                                            input logic signed [DEG_W-1:0] pol);
    longint    ca, sa, cp, sp;
    unit_vec_t v;
    trig_q30(az, ca, sa);
    trig_q30(pol, cp, sp);
    v.x = sat_q14((ca * sp + (64'sd1 <<< 45)) >>> 46);
    v.y = sat_q14((sa * sp + (64'sd1 <<< 45)) >>> 46);
    v.z = sat_q14((cp + (64'sd1 <<< 15)) >>> 16);
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] result %0d %s: got %0d want %0d", $realtime, n_rcv, what, got, want);
    errors++;
  endtask

  task automatic add_angles(input int az, input int pol, input bit drain = 1'b0);
    angle_item_t it;
    it.az = DEG_W'(az);
    it.pol = DEG_W'(pol);
    it.drain = drain;
    angle_queue.push_back(it);
  endtask

  function automatic int rand_angle();
    case ($urandom_range(0, 19))
      0, 1, 2:  return int'($signed(16'($urandom)));            // any pattern, wraps
      3, 4, 5:  return $urandom_range(0, 16) * 2880 - DEG_RANGE  // octant edges
                       + $urandom_range(0, 6) - 3;
      default:  return $urandom_range(0, 2 * DEG_RANGE) - DEG_RANGE;
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("spherical_angles_to_unit_vector_test NOT OK");
      $finish;
    end
  end

  // driver: bursts of items with random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin : driver
    int unsigned acc_next;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      azimuth    <= '0;
      polar      <= '0;
      gap_left   <= 0;
      burst_left <= 0;
      n_acc      <= 0;
    end else begin
      acc_next = n_acc;
      if (in_valid && in_ready) begin
        expected_dirs.push_back(unit_dir_of(azimuth, polar));
        acc_next = n_acc + 1;
        n_acc <= acc_next;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (angle_queue.size() == 0 ||
                     (angle_queue[0].drain && n_rcv != acc_next)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          azimuth  <= angle_queue[0].az;
          polar    <= angle_queue[0].pol;
          angle_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // monitor: stalls on a rotating mask, checks each accepted result in order
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [7:0] mask_v;
    unit_vec_t  want;
    if (!rst_ni) begin
      out_ready   <= 1'b0;
      stall_mask  <= 8'hFF;
      stall_phase <= '0;
      n_rcv       <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_rcv <= n_rcv + 1;
        if (expected_dirs.size() == 0) begin
          report_mismatch("unexpected result, dir_x", int'(dir_x), 0);
        end else begin
          want = expected_dirs.pop_front();
          if (dir_x !== want.x) report_mismatch("dir_x", int'(dir_x), int'(want.x));
          if (dir_y !== want.y) report_mismatch("dir_y", int'(dir_y), int'(want.y));
          if (dir_z !== want.z) report_mismatch("dir_z", int'(dir_z), int'(want.z));
        end
      end
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0:       mask_v = 8'hFF;
          1:       mask_v = 8'h01;
          default: mask_v = 8'($urandom);
        endcase
      end else begin
        mask_v = {stall_mask[0], stall_mask[7:1]};
      end
      stall_mask  <= mask_v;
      out_ready   <= mask_v[0];
      stall_phase <= stall_phase - 1'b1;
    end
  end

  initial begin
    rst_ni = 1'b0;

    // directed: range ends, full 16-bit ends, quadrant and octant edges
    add_angles(0, 0);
    add_angles(-23040, -23040);
    add_angles(23040, 23040);
    add_angles(-32768, 32767);
    add_angles(32767, -32768);
    add_angles(16'sh5555, -16'sh5556);
    add_angles(0, 5760);
    add_angles(5760, 5760);
    add_angles(11520, 11520);
    add_angles(17280, 17280);
    add_angles(-5760, -11520);
    add_angles(2880, 2880);
    add_angles(2879, 2881);
    add_angles(-2880, 8640);
    add_angles(8640, -2880);
    add_angles(5759, 5761);
    add_angles(1, -1);
    add_angles(23039, -23039);
    add_angles(-11520, 17280);
    add_angles(14400, 20160);
    add_angles(23041, -23041);

    for (int i = 0; i < N_RANDOM; i++)
      add_angles(rand_angle(), rand_angle(), i == 0 || i == N_RANDOM / 2);
    n_total = angle_queue.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_acc != n_total) @(posedge clk_i);
    while (n_rcv != n_acc) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_dirs.size() != 0)
      report_mismatch("results missing", 0, expected_dirs.size());
    if (errors == 0) begin
      $display("spherical_angles_to_unit_vector_test OK");
    end else begin
      $display("spherical_angles_to_unit_vector_test NOT OK");
    end
    $finish;
  end

endmodule
